@@ rtl/worst_fit_block_allocator_macros.svh @@
// Assertion macros used by the checker of the allocator.
`ifndef WORST_FIT_BLOCK_ALLOCATOR_MACROS_SVH
`define WORST_FIT_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define WFBA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define WFBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

@@ rtl/wfba_pkg.sv @@
package wfba_pkg;

   // Default sizing of the partition table.
   localparam int DEF_NUM_BLOCKS = 8;
   localparam int DEF_SIZE_BITS  = 16;

   // Fixed field widths of the transactions.
   localparam int INDEX_W       = 3;
   localparam int FIELD_SIZE_W  = 16;
   localparam int ACTIVE_W      = 4;

   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd8;

   // Operation codes.
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_ALLOC = 1'b1;

   typedef struct packed {
      logic                    op;
      logic [INDEX_W-1:0]      block_index;
      logic [FIELD_SIZE_W-1:0] size;
   } req_type;

   typedef struct packed {
      logic                    granted;
      logic [INDEX_W-1:0]      chosen_index;
      logic [FIELD_SIZE_W-1:0] size_left;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_UPDATE
   } state_type;

endpackage

@@ rtl/wfba_table.sv @@
module wfba_table import wfba_pkg::*; #(
   parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
   parameter int SIZE_BITS  = DEF_SIZE_BITS,
   localparam int IDX_BITS  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [IDX_BITS-1:0]  wr_addr,
   input  logic [SIZE_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [IDX_BITS-1:0]  rd_addr,
   output logic [SIZE_BITS-1:0] rd_data
);

   logic [SIZE_BITS-1:0]  mem_ff [NUM_BLOCKS];
   logic [NUM_BLOCKS-1:0] valid_ff;
   logic [SIZE_BITS-1:0]  rd_data_ff;
   logic                  rd_valid_ff;

   // Storage array with a registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   // Per-entry valid bits stand in for clearing the array at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // An entry never written reads as zero.
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

@@ rtl/wfba_ctrl.sv @@
module wfba_ctrl import wfba_pkg::*; #(
   parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
   parameter int SIZE_BITS  = DEF_SIZE_BITS,
   localparam int IDX_BITS  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1,
   localparam int CNT_BITS  = $clog2(NUM_BLOCKS + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   input  logic [ACTIVE_W-1:0]  active_blocks,
   output logic                 wr_en,
   output logic [IDX_BITS-1:0]  wr_addr,
   output logic [SIZE_BITS-1:0] wr_data,
   output logic                 rd_en,
   output logic [IDX_BITS-1:0]  rd_addr,
   input  logic [SIZE_BITS-1:0] rd_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data
);

   state_type            state_ff, state_in;
   logic [SIZE_BITS-1:0] sz_ff, sz_in;
   logic [CNT_BITS-1:0]  limit_ff, limit_in;
   logic [CNT_BITS-1:0]  scan_idx_ff, scan_idx_in;
   logic                 found_ff, found_in;
   logic [IDX_BITS-1:0]  best_idx_ff, best_idx_in;
   logic [SIZE_BITS-1:0] best_val_ff, best_val_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   logic [SIZE_BITS-1:0] req_sz;
   logic                 in_range;
   logic [CNT_BITS-1:0]  limit;
   logic [CNT_BITS-1:0]  scan_next;
   logic [SIZE_BITS-1:0] left;

   // Request size in table width, and the load target check.
   assign req_sz   = SIZE_BITS'(req_data.size);
   assign in_range = (32'(req_data.block_index) < NUM_BLOCKS);

   // The scan covers the active partitions, saturated at the table depth.
   always_comb begin
      if (32'(active_blocks) > NUM_BLOCKS) begin
         limit = CNT_BITS'(NUM_BLOCKS);
      end else begin
         limit = CNT_BITS'(active_blocks);
      end
   end

   assign scan_next = scan_idx_ff + CNT_BITS'(1);
   assign left      = best_val_ff - sz_ff;

   // State and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sz_ff       <= sz_in;
      limit_ff    <= limit_in;
      scan_idx_ff <= scan_idx_in;
      found_ff    <= found_in;
      best_idx_ff <= best_idx_in;
      best_val_ff <= best_val_in;
      rsp_ff      <= rsp_in;
   end

   // Next state, table accesses and the result.
   always_comb begin
      state_in     = state_ff;
      sz_in        = sz_ff;
      limit_in     = limit_ff;
      scan_idx_in  = scan_idx_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_val_in  = best_val_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = best_idx_ff;
      wr_data      = left;
      rd_en        = 1'b0;
      rd_addr      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_data.op == OP_LOAD) begin
                  // A load writes straight through and answers next cycle.
                  rsp_valid_in = 1'b1;
                  if (in_range) begin
                     wr_en               = 1'b1;
                     wr_addr             = IDX_BITS'(req_data.block_index);
                     wr_data             = req_sz;
                     rsp_in.granted      = 1'b1;
                     rsp_in.chosen_index = req_data.block_index;
                     rsp_in.size_left    = FIELD_SIZE_W'(req_sz);
                  end else begin
                     rsp_in = '0;
                  end
               end else begin
                  sz_in       = req_sz;
                  found_in    = 1'b0;
                  best_idx_in = '0;
                  best_val_in = '0;
                  if (limit == '0) begin
                     // Nothing to scan: answer not granted at once.
                     rsp_valid_in = 1'b1;
                     rsp_in       = '0;
                  end else begin
                     rd_en       = 1'b1;
                     rd_addr     = '0;
                     scan_idx_in = '0;
                     limit_in    = limit;
                     state_in    = ST_SCAN;
                  end
               end
            end
         end

         ST_SCAN: begin
            // Entry scan_idx_ff is on the read port; keep the largest fit.
            if ((rd_data >= sz_ff) && (!found_ff || (rd_data > best_val_ff))) begin
               found_in    = 1'b1;
               best_idx_in = scan_idx_ff[IDX_BITS-1:0];
               best_val_in = rd_data;
            end
            if (scan_next == limit_ff) begin
               state_in = ST_UPDATE;
            end else begin
               rd_en       = 1'b1;
               rd_addr     = scan_next[IDX_BITS-1:0];
               scan_idx_in = scan_next;
            end
         end

         ST_UPDATE: begin
            // Write back the reduced size of the chosen partition.
            rsp_valid_in = 1'b1;
            if (found_ff) begin
               wr_en               = 1'b1;
               rsp_in.granted      = 1'b1;
               rsp_in.chosen_index = INDEX_W'(best_idx_ff);
               rsp_in.size_left    = FIELD_SIZE_W'(left);
            end else begin
               rsp_in = '0;
            end
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ rtl/worst_fit_block_allocator.sv @@
// Worst-fit partition allocator. A load transaction is taken while busy is low and its result
// shows in the next cycle, so loads may arrive back to back. An allocation request scans the
// active partitions one table entry per cycle through the single read port of the table,
// min(active_blocks, NUM_BLOCKS) entries, then does the write-back: busy is high through both
// and the result shows in the cycle busy falls. A request with zero active partitions is
// answered in the next cycle, with no scan. Results are presented for exactly one cycle on
// rsp_valid and cannot be stalled. Write csr_wr_data only while the block is idle; it resets to
// eight.
module worst_fit_block_allocator import wfba_pkg::*; #(
   parameter int NUM_BLOCKS = DEF_NUM_BLOCKS,
   parameter int SIZE_BITS  = DEF_SIZE_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  req_type             req_data,
   output logic                rsp_valid,
   output rsp_type             rsp_data,
   input  logic                csr_wr_en,
   input  logic [ACTIVE_W-1:0] csr_wr_data
);

   localparam int IDX_BITS = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

   logic [ACTIVE_W-1:0]  active_ff;
   logic                 wr_en;
   logic [IDX_BITS-1:0]  wr_addr;
   logic [SIZE_BITS-1:0] wr_data;
   logic                 rd_en;
   logic [IDX_BITS-1:0]  rd_addr;
   logic [SIZE_BITS-1:0] rd_data;

   // Active partition count register.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
      end else if (csr_wr_en) begin
         active_ff <= csr_wr_data;
      end
   end

   wfba_ctrl #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_data      (req_data),
      .active_blocks (active_ff),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data)
   );

   wfba_table #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

@@ rtl/wfba_checker.sv @@
`include "worst_fit_block_allocator_macros.svh"

module wfba_checker import wfba_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   logic load_acc;
   logic refused;
   logic zero_fields;

   // Accepted load transactions, refusals and an all-zero result payload.
   assign load_acc    = start && !busy && (req_data.op == OP_LOAD);
   assign refused     = rsp_valid && !rsp_data.granted;
   assign zero_fields = (rsp_data.chosen_index == '0) && (rsp_data.size_left == '0);

   // A load transaction is answered in the following cycle.
   `WFBA_ASSERT_NEXT(a_load_answer, clock, reset, load_acc, rsp_valid)

   // No result is presented while a request is still being worked on.
   `WFBA_ASSERT_NOW(a_no_rsp_busy, clock, reset, busy, !rsp_valid)

   // The end of a request's work always comes with its result.
   `WFBA_ASSERT_NOW(a_fell_rsp, clock, reset, $fell(busy), rsp_valid)

   // A refusal carries zero index and zero size.
   `WFBA_ASSERT_NOW(a_refuse_zero, clock, reset, refused, zero_fields)

endmodule

bind worst_fit_block_allocator wfba_checker u_wfba_checker (.*);
